>>> hw/rtl/efra_pkg.sv
package efra_pkg;

  localparam int CFG_W      = 5;
  localparam int TIME_W     = 32;
  localparam int END_W      = 40;
  localparam int CNT_W      = 32;
  localparam int ROOM_OUT_W = 4;

  localparam logic [END_W-1:0] END_MAX     = {END_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] ROOMS_RESET = 5'd16;

  // Partial result carried along the chain of room cells
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] free_cnt;
    logic [END_W-1:0] min_end;
    logic [CNT_W-1:0] min_cnt;
    logic [CNT_W-1:0] best_cnt;
  } scan_data_t;

  // Update broadcast to the cells; the target index travels beside it
  typedef struct packed {
    logic             en;
    logic [END_W-1:0] end_time;
    logic [CNT_W-1:0] cnt;
  } cell_wr_t;

endpackage

>>> hw/rtl/efra_cell.sv
module efra_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [efra_pkg::CFG_W-1:0]   rooms,
  input  logic [efra_pkg::TIME_W-1:0]  start,
  input  logic                         in_vld,
  input  efra_pkg::scan_data_t         in_data,
  input  logic [IDX_W-1:0]             in_free_idx,
  input  logic [IDX_W-1:0]             in_min_idx,
  input  logic [IDX_W-1:0]             in_best_idx,
  input  efra_pkg::cell_wr_t           wr,
  input  logic [IDX_W-1:0]             wr_idx,
  output logic                         out_vld,
  output efra_pkg::scan_data_t         out_data,
  output logic [IDX_W-1:0]             out_free_idx,
  output logic [IDX_W-1:0]             out_min_idx,
  output logic [IDX_W-1:0]             out_best_idx
);
  import efra_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [END_W-1:0] end_time;
  logic [CNT_W-1:0] use_count;

  logic       active;
  logic       take_free;
  logic       take_min;
  logic       take_best;
  scan_data_t data_next;
  logic [IDX_W-1:0] free_idx_next;
  logic [IDX_W-1:0] min_idx_next;
  logic [IDX_W-1:0] best_idx_next;

  // cells past the room count pass the beat through untouched
  always_comb begin
    active    = (IDX == 0) || (int'(rooms) > IDX);
    take_free = active && !in_data.found && (end_time <= END_W'(start));
    take_min  = active && ((IDX == 0) || (end_time < in_data.min_end));
    take_best = active && ((IDX == 0) || (use_count > in_data.best_cnt));

    data_next     = in_data;
    free_idx_next = in_free_idx;
    min_idx_next  = in_min_idx;
    best_idx_next = in_best_idx;
    if (take_free) begin
      data_next.found    = 1'b1;
      data_next.free_cnt = use_count;
      free_idx_next      = MY_IDX;
    end
    if (take_min) begin
      data_next.min_end = end_time;
      data_next.min_cnt = use_count;
      min_idx_next      = MY_IDX;
    end
    if (take_best) begin
      data_next.best_cnt = use_count;
      best_idx_next      = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld   <= 1'b0;
      end_time  <= '0;
      use_count <= '0;
    end else begin
      out_vld <= in_vld;
      if (wr.en && (wr_idx == MY_IDX)) begin
        end_time  <= wr.end_time;
        use_count <= wr.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data     <= data_next;
    out_free_idx <= free_idx_next;
    out_min_idx  <= min_idx_next;
    out_best_idx <= best_idx_next;
  end

endmodule

>>> hw/rtl/earliest_free_room_allocator.sv
// Earliest-free room allocator.
// Input channel (in_valid / in_stall): one booking per beat, start_time and
// finish_time, expected in non-decreasing start order.
// Output channel (out_valid / out_stall): one result beat per booking with
// room_assigned, actual_end and most_booked_room.
// Config channel (cfg_valid / cfg_ready, cfg_data): the room count. cfg_ready
// is always high; write only while the block is idle. 0 acts as 1, values
// above NUM_ROOMS act as NUM_ROOMS. Rooms keep their state across writes.
// Operation: each room is one cell in a chain. A scan beat enters cell 0 the
// cycle after acceptance and moves one cell per cycle, collecting the first
// free room, the soonest-ending room and the most-booked room. The chain
// always runs its full length of NUM_ROOMS cells.
// The result is then held in the result registers and in the output register.
// One booking is in flight at a time; the next is taken only once the result
// has been loaded into the output register.
// in_stall is high from acceptance until the result is loaded into the output
// register. If the receiver stalls, the finished result waits in the chain
// controller and the block takes no new booking until the output frees up.
// Reset (rst, synchronous): all rooms free, all use counts zero, room count 16.
module earliest_free_room_allocator #(
  parameter int NUM_ROOMS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [efra_pkg::TIME_W-1:0]      start_time,
  input  logic [efra_pkg::TIME_W-1:0]      finish_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [efra_pkg::ROOM_OUT_W-1:0]  room_assigned,
  output logic [efra_pkg::END_W-1:0]       actual_end,
  output logic [efra_pkg::ROOM_OUT_W-1:0]  most_booked_room,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [efra_pkg::CFG_W-1:0]       cfg_data
);
  import efra_pkg::*;

  localparam int IDX_W = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  rooms;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] dur_q;
  logic              inject;

  // chain taps: tap 0 is the seed beat, tap NUM_ROOMS the chain output
  logic              tap_vld      [0:NUM_ROOMS];
  scan_data_t        tap_data     [0:NUM_ROOMS];
  logic [IDX_W-1:0]  tap_free_idx [0:NUM_ROOMS];
  logic [IDX_W-1:0]  tap_min_idx  [0:NUM_ROOMS];
  logic [IDX_W-1:0]  tap_best_idx [0:NUM_ROOMS];

  cell_wr_t          wr;
  logic [IDX_W-1:0]  res_room;
  logic [END_W-1:0]  res_end;
  logic [CNT_W-1:0]  res_cnt;
  logic [IDX_W-1:0]  res_best;

  logic              in_fire;
  logic              slot_free;
  logic [TIME_W-1:0] dur_in;

  scan_data_t        last;
  logic              sel_found;
  logic [IDX_W-1:0]  sel_room;
  logic [CNT_W-1:0]  sel_cnt_old;
  logic [CNT_W-1:0]  sel_cnt_new;
  logic [END_W:0]    sel_sum;
  logic [END_W-1:0]  sel_end;
  logic [IDX_W-1:0]  sel_best;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // a booking that does not end after its start has zero length
  assign dur_in = (finish_time > start_time) ? (finish_time - start_time) : '0;

  // seed beat
  assign tap_vld[0]      = inject;
  assign tap_data[0]     = '0;
  assign tap_free_idx[0] = '0;
  assign tap_min_idx[0]  = '0;
  assign tap_best_idx[0] = '0;

  for (genvar g = 0; g < NUM_ROOMS; g++) begin : g_cell
    efra_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .rooms        (rooms),
      .start        (start_q),
      .in_vld       (tap_vld[g]),
      .in_data      (tap_data[g]),
      .in_free_idx  (tap_free_idx[g]),
      .in_min_idx   (tap_min_idx[g]),
      .in_best_idx  (tap_best_idx[g]),
      .wr           (wr),
      .wr_idx       (res_room),
      .out_vld      (tap_vld[g+1]),
      .out_data     (tap_data[g+1]),
      .out_free_idx (tap_free_idx[g+1]),
      .out_min_idx  (tap_min_idx[g+1]),
      .out_best_idx (tap_best_idx[g+1])
    );
  end

  // Pick the room from the chain output. The most-booked room follows from
  // the pre-update leader and the one count that changes.
  always_comb begin
    last        = tap_data[NUM_ROOMS];
    sel_found   = last.found;
    sel_room    = sel_found ? tap_free_idx[NUM_ROOMS] : tap_min_idx[NUM_ROOMS];
    sel_cnt_old = sel_found ? last.free_cnt : last.min_cnt;
    sel_cnt_new = (sel_cnt_old == CNT_MAX) ? sel_cnt_old : sel_cnt_old + 1'b1;
    if (sel_found) begin
      sel_sum = (END_W+1)'(start_q) + (END_W+1)'(dur_q);
    end else begin
      sel_sum = {1'b0, last.min_end} + (END_W+1)'(dur_q);
    end
    sel_end = sel_sum[END_W] ? END_MAX : sel_sum[END_W-1:0];
    if ((sel_cnt_new > last.best_cnt) ||
        ((sel_cnt_new == last.best_cnt) && (sel_room < tap_best_idx[NUM_ROOMS]))) begin
      sel_best = sel_room;
    end else begin
      sel_best = tap_best_idx[NUM_ROOMS];
    end
  end

  // room write-back coincides with loading the output register
  always_comb begin
    wr.en       = (state == ST_DONE) && slot_free;
    wr.end_time = res_end;
    wr.cnt      = res_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rooms     <= ROOMS_RESET;
      inject    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      inject <= in_fire;
      if (cfg_valid && cfg_ready) begin
        rooms <= cfg_data;
      end
      // a new result beat replaces the one leaving in the same cycle
      if ((state == ST_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tap_vld[NUM_ROOMS]) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_q <= start_time;
      dur_q   <= dur_in;
    end
    if ((state == ST_SCAN) && tap_vld[NUM_ROOMS]) begin
      res_room <= sel_room;
      res_end  <= sel_end;
      res_cnt  <= sel_cnt_new;
      res_best <= sel_best;
    end
    if ((state == ST_DONE) && slot_free) begin
      room_assigned    <= ROOM_OUT_W'(res_room);
      actual_end       <= res_end;
      most_booked_room <= ROOM_OUT_W'(res_best);
    end
  end

endmodule

>>> hw/rtl/efra_chk.sv
module efra_chk #(
  parameter int NUM_ROOMS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [efra_pkg::ROOM_OUT_W-1:0]  room_assigned,
  input logic [efra_pkg::END_W-1:0]       actual_end,
  input logic [efra_pkg::ROOM_OUT_W-1:0]  most_booked_room
);
  import efra_pkg::*;

  // one booking in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("booking accepted while another is in flight");

  // result needs the chain walk; none can follow acceptance at once
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared without a chain walk");

  // rooms past the array never come out
  a_room_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((NUM_ROOMS >= 16) || (int'(room_assigned) < NUM_ROOMS)))
    else $error("assigned room outside the room array");

  a_best_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((NUM_ROOMS >= 16) || (int'(most_booked_room) < NUM_ROOMS)))
    else $error("most-booked room outside the room array");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(actual_end)))
    else $error("stalled result beat changed");

endmodule

bind earliest_free_room_allocator efra_chk #(
  .NUM_ROOMS (NUM_ROOMS)
) u_efra_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .room_assigned    (room_assigned),
  .actual_end       (actual_end),
  .most_booked_room (most_booked_room)
);
